// ===== rtl/core/sphc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sphc_pkg: shared types and constants of the stepper position controller
// Operation and status codes, register indexes and sizing constants used by
// the channel interfaces and by the controller.
// ----------------------------------------------------------------------------
package sphc_pkg;

   localparam int SEQ_LEN     = 16;
   localparam int PHASE_LINES = 4;
   localparam int HOME_STEPS  = 1000;

   localparam int IDX_W   = 4;
   localparam int POS_W   = 16;
   localparam int MAXP_W  = 15;
   localparam int TABLE_W = 64;
   localparam int PHASE_W = 4;

   localparam logic [PHASE_W-1:0] PHASE_MASK = PHASE_W'((1 << PHASE_LINES) - 1);
   localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(SEQ_LEN - 1);
   localparam logic [MAXP_W-1:0]  MAXP_RESET = MAXP_W'(1000);

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_MOVE  = 2'd1,
      OP_HOME  = 2'd2,
      OP_LIMIT = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_NONE     = 3'd0,
      ST_OK       = 3'd1,
      ST_HOMEFAIL = 3'd2,
      ST_RANGE    = 3'd3,
      ST_BUSY     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      REG_POS_LIMIT     = 2'd0,
      REG_FORWARD_TABLE = 2'd1,
      REG_REVERSE_TABLE = 2'd2
   } reg_index_type;

   typedef struct packed {
      status_type        status;
      logic              start;
      logic              reverse;
      logic [POS_W-1:0]  steps;
   } move_type;

endpackage
`default_nettype wire

// ===== rtl/core/sphc_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sphc channel interfaces
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
interface sphc_req_if;
   logic                        valid;
   logic                        ready;
   sphc_pkg::op_type            operation;
   logic signed [15:0]          goal_position;
   logic                        limit_level;

   modport source (output valid, output operation, output goal_position,
                   output limit_level, input ready);
   modport sink   (input valid, input operation, input goal_position,
                   input limit_level, output ready);
endinterface

interface sphc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [3:0]                  coil_drive;
   logic signed [15:0]          position_now;
   logic                        homed_flag;
   logic                        busy_flag;
   sphc_pkg::status_type        status_code;

   modport source (output valid, output coil_drive, output position_now,
                   output homed_flag, output busy_flag, output status_code,
                   input ready);
   modport sink   (input valid, input coil_drive, input position_now,
                   input homed_flag, input busy_flag, input status_code,
                   output ready);
endinterface

interface sphc_csr_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  index;
   logic [63:0]                 data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/stepper_position_homing_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_position_homing_controller: stepper drive with limit-switch homing
// Runs moves and homing one step per tick item and reports phase drive,
// position, flags and a status code for every item.
// ----------------------------------------------------------------------------
// The result of an item is registered and appears in the cycle after the item is transferred.
// Throughput: one item per cycle while each result is taken; the state update
// and the result are formed in a single pass into the output register, which frees as it is taken.
// Reset: clears position, flags, run state and phase drive; the position
// limit returns to 1000 and both pattern tables to zero.
module stepper_position_homing_controller (
   input  wire       clock,
   input  wire       reset,
   sphc_req_if.sink  req_ch,
   sphc_rsp_if.source rsp_ch,
   sphc_csr_if.sink  csr_ch
);

   localparam int POS_W = sphc_pkg::POS_W;

   // Configuration registers
   logic [sphc_pkg::MAXP_W-1:0]  max_pos_ff;
   logic [sphc_pkg::TABLE_W-1:0] fwd_table_ff;
   logic [sphc_pkg::TABLE_W-1:0] rev_table_ff;

   // Controller state
   logic signed [POS_W-1:0]      pos_ff, pos_in;
   logic                         homed_ff, homed_in;
   logic                         busy_ff, busy_in;
   logic                         rev_ff, rev_in;
   logic [POS_W-1:0]             steps_ff, steps_in;
   logic [sphc_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic                         homing_ff, homing_in;
   logic signed [POS_W-1:0]      pend_t_ff, pend_t_in;
   logic                         pend_v_ff, pend_v_in;
   logic [sphc_pkg::PHASE_W-1:0] drive_ff, drive_in;

   // Result register
   logic                         rsp_valid_ff;
   sphc_pkg::status_type         status_ff, status_in;

   logic                         req_take;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.coil_drive    = drive_ff;
   assign rsp_ch.position_now  = pos_ff;
   assign rsp_ch.homed_flag    = homed_ff;
   assign rsp_ch.busy_flag     = busy_ff;
   assign rsp_ch.status_code   = status_ff;

   // Range check and run setup for a move toward an absolute target.
   function automatic sphc_pkg::move_type start_move(
      input logic signed [POS_W-1:0]        tgt,
      input logic signed [POS_W-1:0]        pos,
      input logic [sphc_pkg::MAXP_W-1:0]    maxp
   );
      logic signed [POS_W:0]   diff;
      logic signed [POS_W:0]   mag;
      sphc_pkg::move_type      mv;
      mv = '0;
      diff = (POS_W+1)'(tgt) - (POS_W+1)'(pos);
      mag  = (diff < 0) ? -diff : diff;
      mv.status = sphc_pkg::ST_NONE;
      if (tgt < 0 || tgt > $signed({1'b0, maxp})) begin
         mv.status = sphc_pkg::ST_RANGE;
      end else if (diff == 0) begin
         mv.status = sphc_pkg::ST_OK;
      end else begin
         mv.start   = 1'b1;
         mv.reverse = diff < 0;
         mv.steps   = mag[POS_W-1:0];
      end
      return mv;
   endfunction

   always_comb begin
      logic                               finish;
      logic [sphc_pkg::TABLE_W-1:0]       table_sel;
      sphc_pkg::move_type                 mv;
      pos_in    = pos_ff;
      homed_in  = homed_ff;
      busy_in   = busy_ff;
      rev_in    = rev_ff;
      steps_in  = steps_ff;
      idx_in    = idx_ff;
      homing_in = homing_ff;
      pend_t_in = pend_t_ff;
      pend_v_in = pend_v_ff;
      drive_in  = drive_ff;
      status_in = sphc_pkg::ST_NONE;
      finish    = 1'b0;
      table_sel = rev_ff ? rev_table_ff : fwd_table_ff;
      mv        = '0;

      unique case (req_ch.operation)
         sphc_pkg::OP_TICK: begin
            if (busy_ff) begin
               if (rev_ff && req_ch.limit_level) begin
                  // The limit switch marks home: the run stops right here.
                  pos_in   = '0;
                  homed_in = 1'b1;
                  finish   = 1'b1;
               end else begin
                  if (steps_ff != '0) begin
                     drive_in = table_sel[{idx_ff, 2'b00} +: sphc_pkg::PHASE_W]
                                & sphc_pkg::PHASE_MASK;
                     idx_in   = (idx_ff == sphc_pkg::IDX_LAST) ? '0 : idx_ff + 1'b1;
                     if (rev_ff) begin
                        if (pos_ff != {1'b1, {(POS_W-1){1'b0}}}) pos_in = pos_ff - 1'b1;
                     end else begin
                        if (pos_ff != {1'b0, {(POS_W-1){1'b1}}}) pos_in = pos_ff + 1'b1;
                     end
                     steps_in = steps_ff - 1'b1;
                  end
                  finish = (steps_in == '0);
               end

               if (finish) begin
                  drive_in  = '0;
                  busy_in   = 1'b0;
                  homing_in = 1'b0;
                  steps_in  = '0;
                  if (!homing_ff) begin
                     status_in = sphc_pkg::ST_OK;
                  end else if (!homed_in) begin
                     pend_v_in = 1'b0;
                     status_in = sphc_pkg::ST_HOMEFAIL;
                  end else if (pend_v_ff) begin
                     // Homing done, so the move that asked for it goes ahead now.
                     pend_v_in = 1'b0;
                     mv        = start_move(pend_t_ff, pos_in, max_pos_ff);
                     status_in = mv.status;
                     if (mv.start) begin
                        rev_in   = mv.reverse;
                        steps_in = mv.steps;
                        idx_in   = '0;
                        busy_in  = 1'b1;
                     end
                  end else begin
                     status_in = sphc_pkg::ST_OK;
                  end
               end
            end
         end

         sphc_pkg::OP_MOVE: begin
            if (busy_ff) begin
               status_in = sphc_pkg::ST_BUSY;
            end else if (!homed_ff) begin
               pend_t_in = req_ch.goal_position;
               pend_v_in = 1'b1;
               rev_in    = 1'b1;
               steps_in  = POS_W'(sphc_pkg::HOME_STEPS);
               idx_in    = '0;
               homing_in = 1'b1;
               busy_in   = 1'b1;
            end else begin
               mv        = start_move(req_ch.goal_position, pos_ff, max_pos_ff);
               status_in = mv.status;
               if (mv.start) begin
                  rev_in    = mv.reverse;
                  steps_in  = mv.steps;
                  idx_in    = '0;
                  homing_in = 1'b0;
                  busy_in   = 1'b1;
               end
            end
         end

         sphc_pkg::OP_HOME: begin
            if (busy_ff) begin
               status_in = sphc_pkg::ST_BUSY;
            end else begin
               pend_v_in = 1'b0;
               rev_in    = 1'b1;
               steps_in  = POS_W'(sphc_pkg::HOME_STEPS);
               idx_in    = '0;
               homing_in = 1'b1;
               busy_in   = 1'b1;
            end
         end

         sphc_pkg::OP_LIMIT: begin
            drive_in = '0;
            if (pos_ff < 0) begin
               pos_in   = '0;
               homed_in = 1'b1;
            end
         end

         default: begin
            status_in = sphc_pkg::ST_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_pos_ff   <= sphc_pkg::MAXP_RESET;
         fwd_table_ff <= '0;
         rev_table_ff <= '0;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            sphc_pkg::REG_POS_LIMIT:     max_pos_ff   <= csr_ch.data[sphc_pkg::MAXP_W-1:0];
            sphc_pkg::REG_FORWARD_TABLE: fwd_table_ff <= csr_ch.data;
            sphc_pkg::REG_REVERSE_TABLE: rev_table_ff <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         homed_ff     <= 1'b0;
         busy_ff      <= 1'b0;
         rev_ff       <= 1'b0;
         steps_ff     <= '0;
         idx_ff       <= '0;
         homing_ff    <= 1'b0;
         pend_t_ff    <= '0;
         pend_v_ff    <= 1'b0;
         drive_ff     <= '0;
         status_ff    <= sphc_pkg::ST_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            pos_ff       <= pos_in;
            homed_ff     <= homed_in;
            busy_ff      <= busy_in;
            rev_ff       <= rev_in;
            steps_ff     <= steps_in;
            idx_ff       <= idx_in;
            homing_ff    <= homing_in;
            pend_t_ff    <= pend_t_in;
            pend_v_ff    <= pend_v_in;
            drive_ff     <= drive_in;
            status_ff    <= status_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // A run in progress always has steps still to go.
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> steps_ff != '0)
      else $error("busy with no steps left");

   // A held move only exists while its homing run is under way.
   assert property (@(posedge clock) disable iff (reset)
      pend_v_ff |-> (busy_ff && homing_ff))
      else $error("pending move without homing run");

   // Phases are off whenever no run is in progress.
   assert property (@(posedge clock) disable iff (reset) !busy_ff |-> drive_ff == '0)
      else $error("phases driven while idle");

   // Every transferred item leaves a result in the output register.
   assert property (@(posedge clock) disable iff (reset) req_take |=> rsp_valid_ff)
      else $error("result missing after transfer");

endmodule
`default_nettype wire
